// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msa port check failed");

// next-cycle implication
`define MSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msa port check failed");

`endif

// ===== rtl/msa_pkg.sv =====
`timescale 1ns / 1ps
package msa_pkg;

  localparam int MAX_POSITIONS_DEF = 256;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 16;
  localparam int VAL_MAX           = 8388607;
  localparam int VAL_MIN           = -8388608;

  // request opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // hold direction codes
  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_UP   = 2'd1;
  localparam logic [1:0] HOLD_DOWN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POSITIONS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_WAIT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP    = 3'd6;

  // register reset values
  localparam logic [8:0]         RST_NUM_POSITIONS = 9'd2;
  localparam logic signed [15:0] RST_MIN_VALUE     = 16'sd0;
  localparam logic signed [15:0] RST_STEP_SIZE     = 16'sd256;
  localparam logic signed [8:0]  RST_SPRING        = -9'sd1;
  localparam logic [15:0]        RST_HOLD_WAIT     = 16'd500;
  localparam logic [15:0]        RST_REPEAT_GAP    = 16'd100;

  typedef struct packed {
    logic [1:0] op;
    logic       direction;
    logic [7:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic               changed;
    logic [7:0]         position;
    logic signed [23:0] value;
  } out_item_t;

  typedef struct packed {
    logic [8:0]         num_positions;
    logic signed [15:0] min_value;
    logic signed [15:0] step_size;
    logic signed [8:0]  spring_low;
    logic signed [8:0]  spring_high;
    logic [15:0]        hold_wait;
    logic [15:0]        repeat_gap;
  } cfg_t;

endpackage

// ===== rtl/msa_cfg.sv =====
`timescale 1ns / 1ps
module msa_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msa_pkg::CFG_DATA_W-1:0] cfg_data,
  output msa_pkg::cfg_t                  cfg
);
  import msa_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_POSITIONS: cfg_nxt.num_positions = cfg_data[8:0];
        REG_MIN_VALUE:     cfg_nxt.min_value     = signed'(cfg_data);
        REG_STEP_SIZE:     cfg_nxt.step_size     = signed'(cfg_data);
        REG_SPRING_LOW:    cfg_nxt.spring_low    = signed'(cfg_data[8:0]);
        REG_SPRING_HIGH:   cfg_nxt.spring_high   = signed'(cfg_data[8:0]);
        REG_HOLD_WAIT:     cfg_nxt.hold_wait     = cfg_data;
        REG_REPEAT_GAP:    cfg_nxt.repeat_gap    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_positions <= RST_NUM_POSITIONS;
      cfg_r.min_value     <= RST_MIN_VALUE;
      cfg_r.step_size     <= RST_STEP_SIZE;
      cfg_r.spring_low    <= RST_SPRING;
      cfg_r.spring_high   <= RST_SPRING;
      cfg_r.hold_wait     <= RST_HOLD_WAIT;
      cfg_r.repeat_gap    <= RST_REPEAT_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/msa_step.sv =====
`timescale 1ns / 1ps
module msa_step #(
  parameter  int MAX_POSITIONS = msa_pkg::MAX_POSITIONS_DEF,
  localparam int PW            = $clog2(MAX_POSITIONS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  msa_pkg::in_item_t item,
  input  msa_pkg::cfg_t     cfg,
  output logic              changed,
  output logic [PW-1:0]     position
);
  import msa_pkg::*;

  localparam int XW = PW + 10;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_POSITIONS);
  localparam logic [XW-1:0] TWO_X = XW'(2);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [1:0]    hold_dir_r, hold_dir_nxt;
  logic [15:0]   hold_cnt_r, hold_cnt_nxt;
  logic          sl_done_r, sl_done_nxt;
  logic          sh_done_r, sh_done_nxt;
  logic          changed_r;

  logic [XW-1:0] n_x, n_clamped;
  logic [PW-1:0] top_pos, up_pos, dn_pos, pos_m1;
  logic [16:0]   cnt_sum;
  logic [15:0]   cnt_sat;
  logic          sl_hit, sh_hit;

  // usable position count clamped to 2..MAX_POSITIONS
  assign n_x       = XW'(cfg.num_positions);
  assign n_clamped = (n_x < TWO_X) ? TWO_X : ((n_x > MAX_X) ? MAX_X : n_x);
  assign top_pos   = PW'(n_clamped - XW'(1));

  assign pos_m1 = pos_r - PW'(1);
  assign up_pos = (pos_r >= top_pos) ? top_pos : pos_r + PW'(1);
  assign dn_pos = (pos_r == '0) ? '0 : ((pos_m1 > top_pos) ? top_pos : pos_m1);

  assign cnt_sum = {1'b0, hold_cnt_r} + 17'(item.elapsed);
  assign cnt_sat = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];

  assign sl_hit = !cfg.spring_low[8] && !sl_done_r
               && (XW'(pos_r) == XW'(cfg.spring_low[7:0]));
  assign sh_hit = !cfg.spring_high[8] && !sh_done_r
               && (XW'(pos_r) == XW'(cfg.spring_high[7:0]));

  always_comb begin
    pos_nxt      = pos_r;
    hold_dir_nxt = hold_dir_r;
    hold_cnt_nxt = hold_cnt_r;
    sl_done_nxt  = sl_done_r;
    sh_done_nxt  = sh_done_r;
    unique case (item.op)
      OP_PRESS: begin
        pos_nxt      = item.direction ? dn_pos : up_pos;
        hold_dir_nxt = item.direction ? HOLD_DOWN : HOLD_UP;
        hold_cnt_nxt = '0;
        sl_done_nxt  = 1'b0;
        sh_done_nxt  = 1'b0;
      end
      OP_RELEASE: begin
        hold_dir_nxt = HOLD_NONE;
        hold_cnt_nxt = '0;
      end
      OP_TICK: begin
        if (hold_dir_r != HOLD_NONE) begin
          if (cnt_sat >= cfg.hold_wait) begin
            hold_cnt_nxt = (cnt_sat > cfg.repeat_gap) ?
                           cnt_sat - cfg.repeat_gap : '0;
            pos_nxt      = (hold_dir_r == HOLD_UP) ? up_pos : dn_pos;
          end else begin
            hold_cnt_nxt = cnt_sat;
          end
        end else if (sl_hit) begin
          // low spring pushes one place up
          sl_done_nxt = 1'b1;
          pos_nxt     = up_pos;
        end else if (sh_hit) begin
          sh_done_nxt = 1'b1;
          pos_nxt     = dn_pos;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      hold_dir_r <= HOLD_NONE;
      hold_cnt_r <= '0;
      sl_done_r  <= 1'b0;
      sh_done_r  <= 1'b0;
      changed_r  <= 1'b0;
    end else if (go) begin
      pos_r      <= pos_nxt;
      hold_dir_r <= hold_dir_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      sl_done_r  <= sl_done_nxt;
      sh_done_r  <= sh_done_nxt;
      changed_r  <= (pos_nxt != pos_r);
    end
  end

  assign changed  = changed_r;
  assign position = pos_r;

endmodule

// ===== rtl/msa_value.sv =====
`timescale 1ns / 1ps
module msa_value #(
  parameter  int MAX_POSITIONS = msa_pkg::MAX_POSITIONS_DEF,
  localparam int PW            = $clog2(MAX_POSITIONS)
) (
  input  logic               clk,
  input  logic               go,
  input  logic               changed,
  input  logic [PW-1:0]      position,
  input  msa_pkg::cfg_t      cfg,
  output msa_pkg::out_item_t result
);
  import msa_pkg::*;

  localparam int SW = (PW + 18 > 25) ? PW + 18 : 25;
  localparam logic signed [SW-1:0] SAT_HI = SW'(VAL_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(VAL_MIN);

  logic signed [PW+16:0] prod;
  logic signed [SW-1:0]  sum;
  logic signed [23:0]    value_sat;
  out_item_t             result_r;

  assign prod = $signed({1'b0, position}) * cfg.step_size;
  assign sum  = SW'(prod) + SW'(cfg.min_value);

  always_comb begin
    if (sum > SAT_HI) begin
      value_sat = 24'(SAT_HI);
    end else if (sum < SAT_LO) begin
      value_sat = 24'(SAT_LO);
    end else begin
      value_sat = sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result_r.changed  <= changed;
      result_r.position <= 8'(position);
      result_r.value    <= value_sat;
    end
  end

  assign result = result_r;

endmodule

// ===== rtl/multiposition_switch_autorepeat_top.sv =====
// channel   | direction | handshake            | payload
// in_       | in        | in_valid / in_stall  | in_data (op, direction, elapsed)
// out_      | out       | out_valid / out_stall| out_data (changed, position, value)
// cfg_      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one request per cycle unless out_stall back-pressure holds the pipe; each taken request passes in order through
// the stages (input register, state update, multiply and saturate)
// the rate is set by the state update stage: position and hold count feed the next request
// rst_n is synchronous; it clears the pipeline, switch state and registers to their defaults
// out_stall holds all three stages; in_stall rises only when every stage is full and stalled
`timescale 1ns / 1ps
module multiposition_switch_autorepeat_top #(
  parameter int MAX_POSITIONS = msa_pkg::MAX_POSITIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  msa_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output msa_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import msa_pkg::*;

  localparam int PW = $clog2(MAX_POSITIONS);

  cfg_t          cfg;
  in_item_t      in_r;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s2_valid_r, s2_valid_nxt;
  logic          s3_valid_r, s3_valid_nxt;
  logic          s3_take, s2_take, s1_take;
  logic          s2_move, s1_move, in_accept;
  logic          s2_changed;
  logic [PW-1:0] s2_pos;

  // back-pressure from the output register upwards
  assign s3_take   = !s3_valid_r || !out_stall;
  assign s2_move   = s2_valid_r && s3_take;
  assign s2_take   = !s2_valid_r || s3_take;
  assign s1_move   = s1_valid_r && s2_take;
  assign s1_take   = !s1_valid_r || s2_take;
  assign in_accept = in_valid && s1_take;
  assign in_stall  = !s1_take;

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
  assign s2_valid_nxt = s1_move   ? 1'b1 : (s2_move ? 1'b0 : s2_valid_r);
  assign s3_valid_nxt = s2_move   ? 1'b1 : (s3_take ? 1'b0 : s3_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
  end

  msa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msa_step #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (s1_move),
    .item     (in_r),
    .cfg      (cfg),
    .changed  (s2_changed),
    .position (s2_pos)
  );

  msa_value #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_value (
    .clk      (clk),
    .go       (s2_move),
    .changed  (s2_changed),
    .position (s2_pos),
    .cfg      (cfg),
    .result   (out_data)
  );

  assign out_valid = s3_valid_r;

endmodule

// ===== rtl/msa_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input msa_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready
);
  import msa_pkg::*;

  // a stalled result stays put
  `MSA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // input side only blocks when the whole pipe is full behind a stalled result
  `MSA_ASSERT_IMP(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // back-to-back results: no change reported means same position and value
  `MSA_ASSERT_IMP(a_unchanged_pos, clk, rst_n, out_valid && !out_stall ##1 out_valid && !out_stall && !out_data.changed, out_data.position == $past(out_data.position) && out_data.value == $past(out_data.value))

  // register writes are never held off
  `MSA_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind multiposition_switch_autorepeat_top msa_checker u_msa_checker (.*);
